>>> design/qafr_pkg.sv
// Package for the quaternion attitude and frame rotation block.
// Holds widths, constants, the arctangent table, lane types and helpers.
// Depends on nothing; the top level, the square root cell and the CORDIC cell use it.
package qafr_pkg;

   localparam int ANGLE_STEPS_DEFAULT = 24;
   localparam int GRAVITY_W = 22;
   localparam logic [GRAVITY_W-1:0] GRAVITY_RESET = 22'd642690;
   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_IDX_GRAVITY = 1'b0;

   localparam int LANE_W = 38;
   localparam int ZW = 28;
   localparam int SUM_W = 40;
   localparam int SQRT_STEPS = 31;
   localparam int REM_W = 61;
   localparam int ROOT_W = 62;

   localparam logic signed [SUM_W-1:0] ONE_Q30 = 40'sd1073741824;
   localparam logic signed [ZW-1:0] DEG90 = 28'sd5898240;
   localparam logic signed [ZW-1:0] DEG180 = 28'sd11796480;

   localparam logic [23:0] ATAN_TAB [32] = '{
      24'd2949120, 24'd1740967, 24'd919879, 24'd466945, 24'd234379, 24'd117304,
      24'd58666, 24'd29335, 24'd14668, 24'd7334, 24'd3667, 24'd1833, 24'd917,
      24'd458, 24'd229, 24'd115, 24'd57, 24'd29, 24'd14, 24'd7, 24'd4, 24'd2,
      24'd1, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0
   };

   typedef logic signed [31:0] word_type;
   typedef logic signed [33:0] prod_type;
   typedef logic signed [SUM_W-1:0] wide_type;

   typedef struct packed {
      logic signed [LANE_W-1:0] x;
      logic signed [LANE_W-1:0] y;
      logic signed [ZW-1:0]     z;
   } cordic_lane_type;

   typedef struct packed {
      logic [REM_W-1:0]  v;
      logic [ROOT_W-1:0] res;
   } sqrt_lane_type;

   typedef struct packed {
      logic signed [LANE_W-1:0] roll_y;
      logic signed [LANE_W-1:0] roll_x;
      logic signed [LANE_W-1:0] yaw_y;
      logic signed [LANE_W-1:0] yaw_x;
      logic signed [LANE_W-1:0] pitch_s;
      logic                     sat_hi;
      logic                     sat_lo;
   } angle_ops_type;

   typedef struct packed {
      logic zero_roll;
      logic zero_yaw;
      logic zero_pitch;
      logic sat_hi;
      logic sat_lo;
   } angle_flags_type;

   // Signed Q30 product, rounded toward minus infinity.
   function automatic prod_type mul_q30(input word_type a, input word_type b);
      logic signed [63:0] full;
      full = a * b;
      return full[63:30];
   endfunction

   function automatic word_type sat32(input wide_type v);
      if (v[SUM_W-1:31] == {(SUM_W-31){v[31]}}) begin
         return v[31:0];
      end
      return v[SUM_W-1] ? 32'sh80000000 : 32'sh7fffffff;
   endfunction

   function automatic logic signed [ZW-1:0] clamp_angle(input logic signed [ZW-1:0] z,
                                                        input logic signed [ZW-1:0] lim);
      if (z > lim) begin
         return lim;
      end
      if (z < -lim) begin
         return -lim;
      end
      return z;
   endfunction

endpackage

>>> design/qafr_if.sv
// Item channel interfaces of the quaternion attitude and frame rotation block.
// Valid/ready handshake with the payload fields; no package dependency.
interface qafr_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] quat_w;
   logic signed [31:0] quat_x;
   logic signed [31:0] quat_y;
   logic signed [31:0] quat_z;
   logic signed [31:0] accel_body_x;
   logic signed [31:0] accel_body_y;
   logic signed [31:0] accel_body_z;

   modport source (output valid, quat_w, quat_x, quat_y, quat_z,
                   accel_body_x, accel_body_y, accel_body_z, input ready);
   modport sink (input valid, quat_w, quat_x, quat_y, quat_z,
                 accel_body_x, accel_body_y, accel_body_z, output ready);
endinterface

interface qafr_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] earth_accel_x;
   logic signed [31:0] earth_accel_y;
   logic signed [31:0] earth_accel_z;
   logic signed [31:0] free_accel_x;
   logic signed [31:0] free_accel_y;
   logic signed [31:0] free_accel_z;
   logic signed [24:0] roll_angle;
   logic signed [23:0] pitch_angle;
   logic signed [24:0] yaw_angle;

   modport source (output valid, earth_accel_x, earth_accel_y, earth_accel_z,
                   free_accel_x, free_accel_y, free_accel_z, roll_angle,
                   pitch_angle, yaw_angle, input ready);
   modport sink (input valid, earth_accel_x, earth_accel_y, earth_accel_z,
                 free_accel_x, free_accel_y, free_accel_z, roll_angle,
                 pitch_angle, yaw_angle, output ready);
endinterface

>>> design/quaternion_attitude_and_frame_rotation.sv
// Top level of the quaternion attitude and frame rotation block.
// Depends on qafr_pkg, qafr_if, qafr_delay, qafr_sqrt_cell and qafr_cordic_cell.
//
// The block takes one item per clock cycle whenever the output is not stalled.
// The longest path is the 31-cell square root chain for the pitch cosine
// followed by ANGLE_STEPS CORDIC cells; the rotations run alongside and are
// delayed to meet the angles. The whole pipeline holds while a finished result
// waits at the output and the consumer is not ready. Gravity is written through
// the APB port at byte address 0 and should only change while the block is idle.
module quaternion_attitude_and_frame_rotation #(
   parameter int ANGLE_STEPS = qafr_pkg::ANGLE_STEPS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   qafr_req_if.sink                        req_item,
   qafr_rsp_if.source                      rsp_item,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [qafr_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);

   localparam int LW = qafr_pkg::LANE_W;
   localparam int ST_ROOT = 4 + qafr_pkg::SQRT_STEPS;
   localparam int ST_PRE = ST_ROOT + 1;
   localparam int ST_OUT = ST_PRE + ANGLE_STEPS + 1;
   localparam int DEPTH = ST_OUT + 1;
   localparam logic [qafr_pkg::REM_W-1:0] ONE_Q60 = qafr_pkg::REM_W'(1) << 60;

   logic [DEPTH-1:0] valid_ff;
   logic             adv;
   logic [qafr_pkg::GRAVITY_W-1:0] gravity_ff;

   qafr_pkg::word_type q_ff [4];
   qafr_pkg::word_type a_ff [3];
   qafr_pkg::word_type a1_ff [3];
   qafr_pkg::word_type a2_ff [3];
   qafr_pkg::prod_type p00_ff, p01_ff, p02_ff, p03_ff, p11_ff;
   qafr_pkg::prod_type p12_ff, p13_ff, p22_ff, p23_ff, p33_ff;
   qafr_pkg::wide_type p00, p01, p02, p03, p11, p12, p13, p22, p23, p33;
   qafr_pkg::wide_type s_in;
   qafr_pkg::wide_type grav_w;
   qafr_pkg::word_type r_ff [3][3];
   qafr_pkg::word_type r3_ff [3][3];
   qafr_pkg::word_type r4_ff [3][3];
   qafr_pkg::prod_type pe_ff [3][3];
   qafr_pkg::prod_type pf_ff [3][3];
   qafr_pkg::word_type e_ff [3];
   qafr_pkg::word_type f_ff [3];
   qafr_pkg::angle_ops_type ops_ff;
   qafr_pkg::angle_ops_type ops_root;
   logic signed [30:0] s_small_ff;
   logic signed [61:0] sq_full;
   logic [59:0]        sq_ff;
   logic [qafr_pkg::REM_W-1:0] rem_ff;
   qafr_pkg::sqrt_lane_type sq_chain [qafr_pkg::SQRT_STEPS+1];
   qafr_pkg::cordic_lane_type pre_in [3];
   qafr_pkg::cordic_lane_type pre_ff [3];
   qafr_pkg::cordic_lane_type chain [3][ANGLE_STEPS+1];
   qafr_pkg::angle_flags_type flags_in;
   qafr_pkg::angle_flags_type flags_ff;
   qafr_pkg::angle_flags_type flags_end;
   logic [95:0] earth_end;
   logic [95:0] free_end;
   logic signed [LW-1:0] pitch_c;
   logic signed [qafr_pkg::ZW-1:0] roll_z, yaw_z, pitch_z;

   qafr_pkg::word_type earth_ff [3];
   qafr_pkg::word_type free_ff [3];
   logic signed [24:0] roll_ff;
   logic signed [23:0] pitch_ff;
   logic signed [24:0] yaw_ff;

   function automatic qafr_pkg::cordic_lane_type pre_rotate(input logic signed [LW-1:0] y,
                                                            input logic signed [LW-1:0] x);
      qafr_pkg::cordic_lane_type l;
      l.x = x;
      l.y = y;
      l.z = '0;
      if (x < 0) begin
         if (y >= 0) begin
            l.x = y;
            l.y = -x;
            l.z = qafr_pkg::DEG90;
         end else begin
            l.x = -y;
            l.y = x;
            l.z = -qafr_pkg::DEG90;
         end
      end
      return l;
   endfunction

   // Configuration port.
   assign pready = 1'b1;
   assign prdata = (paddr[2] == qafr_pkg::CSR_IDX_GRAVITY) ?
                   {{(32-qafr_pkg::GRAVITY_W){1'b0}}, gravity_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         gravity_ff <= qafr_pkg::GRAVITY_RESET;
      end else if (psel && penable && pwrite && (paddr[2] == qafr_pkg::CSR_IDX_GRAVITY)) begin
         gravity_ff <= pwdata[qafr_pkg::GRAVITY_W-1:0];
      end
   end

   // Pipeline control.
   assign adv = !valid_ff[DEPTH-1] || rsp_item.ready;
   assign req_item.ready = adv;
   assign rsp_item.valid = valid_ff[DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[DEPTH-2:0], req_item.valid};
      end
   end

   assign p00 = qafr_pkg::wide_type'(p00_ff);
   assign p01 = qafr_pkg::wide_type'(p01_ff);
   assign p02 = qafr_pkg::wide_type'(p02_ff);
   assign p03 = qafr_pkg::wide_type'(p03_ff);
   assign p11 = qafr_pkg::wide_type'(p11_ff);
   assign p12 = qafr_pkg::wide_type'(p12_ff);
   assign p13 = qafr_pkg::wide_type'(p13_ff);
   assign p22 = qafr_pkg::wide_type'(p22_ff);
   assign p23 = qafr_pkg::wide_type'(p23_ff);
   assign p33 = qafr_pkg::wide_type'(p33_ff);
   assign s_in = (p02 - p13) <<< 1;
   assign grav_w = qafr_pkg::wide_type'({{(qafr_pkg::SUM_W-qafr_pkg::GRAVITY_W){1'b0}},
                                         gravity_ff});
   assign sq_full = s_small_ff * s_small_ff;

   // Products, rotation matrix, rotations, angle operands and pitch argument.
   always_ff @(posedge clock) begin
      if (adv) begin
         q_ff[0] <= req_item.quat_w;
         q_ff[1] <= req_item.quat_x;
         q_ff[2] <= req_item.quat_y;
         q_ff[3] <= req_item.quat_z;
         a_ff[0] <= req_item.accel_body_x;
         a_ff[1] <= req_item.accel_body_y;
         a_ff[2] <= req_item.accel_body_z;

         p00_ff <= qafr_pkg::mul_q30(q_ff[0], q_ff[0]);
         p01_ff <= qafr_pkg::mul_q30(q_ff[0], q_ff[1]);
         p02_ff <= qafr_pkg::mul_q30(q_ff[0], q_ff[2]);
         p03_ff <= qafr_pkg::mul_q30(q_ff[0], q_ff[3]);
         p11_ff <= qafr_pkg::mul_q30(q_ff[1], q_ff[1]);
         p12_ff <= qafr_pkg::mul_q30(q_ff[1], q_ff[2]);
         p13_ff <= qafr_pkg::mul_q30(q_ff[1], q_ff[3]);
         p22_ff <= qafr_pkg::mul_q30(q_ff[2], q_ff[2]);
         p23_ff <= qafr_pkg::mul_q30(q_ff[2], q_ff[3]);
         p33_ff <= qafr_pkg::mul_q30(q_ff[3], q_ff[3]);
         a1_ff <= a_ff;

         r_ff[0][0] <= qafr_pkg::sat32(p00 + p11 - p22 - p33);
         r_ff[0][1] <= qafr_pkg::sat32((p12 + p03) <<< 1);
         r_ff[0][2] <= qafr_pkg::sat32((p13 - p02) <<< 1);
         r_ff[1][0] <= qafr_pkg::sat32((p12 - p03) <<< 1);
         r_ff[1][1] <= qafr_pkg::sat32(p00 - p11 + p22 - p33);
         r_ff[1][2] <= qafr_pkg::sat32((p23 + p01) <<< 1);
         r_ff[2][0] <= qafr_pkg::sat32((p13 + p02) <<< 1);
         r_ff[2][1] <= qafr_pkg::sat32((p23 - p01) <<< 1);
         r_ff[2][2] <= qafr_pkg::sat32(p00 - p11 - p22 + p33);
         a2_ff <= a1_ff;
         ops_ff.roll_y  <= LW'((p01 + p23) <<< 1);
         ops_ff.roll_x  <= LW'(qafr_pkg::ONE_Q30 - ((p11 + p22) <<< 1));
         ops_ff.yaw_y   <= LW'((p12 + p03) <<< 1);
         ops_ff.yaw_x   <= LW'(qafr_pkg::ONE_Q30 - ((p22 + p33) <<< 1));
         ops_ff.pitch_s <= LW'(s_in);
         ops_ff.sat_hi  <= s_in >= qafr_pkg::ONE_Q30;
         ops_ff.sat_lo  <= s_in <= -qafr_pkg::ONE_Q30;
         s_small_ff <= ((s_in < qafr_pkg::ONE_Q30) && (s_in > -qafr_pkg::ONE_Q30)) ?
                       s_in[30:0] : 31'sd0;

         for (int j = 0; j < 3; j++) begin
            for (int i = 0; i < 3; i++) begin
               pe_ff[j][i] <= qafr_pkg::mul_q30(r_ff[j][i], a2_ff[j]);
            end
         end
         r3_ff <= r_ff;
         sq_ff <= sq_full[59:0];

         for (int i = 0; i < 3; i++) begin
            e_ff[i] <= qafr_pkg::sat32(qafr_pkg::wide_type'(pe_ff[0][i])
                                       + qafr_pkg::wide_type'(pe_ff[1][i])
                                       + qafr_pkg::wide_type'(pe_ff[2][i])
                                       - ((i == 2) ? grav_w : qafr_pkg::wide_type'(0)));
         end
         r4_ff <= r3_ff;
         rem_ff <= ONE_Q60 - qafr_pkg::REM_W'(sq_ff);

         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               pf_ff[i][j] <= qafr_pkg::mul_q30(r4_ff[i][j], e_ff[j]);
            end
         end

         for (int i = 0; i < 3; i++) begin
            f_ff[i] <= qafr_pkg::sat32(qafr_pkg::wide_type'(pf_ff[i][0])
                                       + qafr_pkg::wide_type'(pf_ff[i][1])
                                       + qafr_pkg::wide_type'(pf_ff[i][2]));
         end
      end
   end

   // Square root chain for the pitch cosine.
   assign sq_chain[0].v = rem_ff;
   assign sq_chain[0].res = '0;

   for (genvar n = 0; n < qafr_pkg::SQRT_STEPS; n++) begin : g_sqrt
      qafr_sqrt_cell #(.STEP(n)) u_cell (
         .clock     (clock),
         .enable    (adv),
         .prev_lane (sq_chain[n]),
         .next_lane (sq_chain[n+1])
      );
   end

   qafr_delay #(.WIDTH($bits(qafr_pkg::angle_ops_type)), .DEPTH(ST_ROOT - 2)) u_ops_dly (
      .clock  (clock),
      .enable (adv),
      .d      (ops_ff),
      .q      (ops_root)
   );

   // Quadrant correction ahead of the CORDIC rows.
   assign pitch_c = LW'(sq_chain[qafr_pkg::SQRT_STEPS].res);

   always_comb begin
      pre_in[0] = pre_rotate(ops_root.roll_y, ops_root.roll_x);
      pre_in[1] = pre_rotate(ops_root.yaw_y, ops_root.yaw_x);
      pre_in[2] = pre_rotate(ops_root.pitch_s, pitch_c);
      flags_in.zero_roll  = (ops_root.roll_y == 0) && (ops_root.roll_x >= 0);
      flags_in.zero_yaw   = (ops_root.yaw_y == 0) && (ops_root.yaw_x >= 0);
      flags_in.zero_pitch = (ops_root.pitch_s == 0);
      flags_in.sat_hi     = ops_root.sat_hi;
      flags_in.sat_lo     = ops_root.sat_lo;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pre_ff <= pre_in;
         flags_ff <= flags_in;
      end
   end

   for (genvar k = 0; k < 3; k++) begin : g_row
      assign chain[k][0] = pre_ff[k];
      for (genvar n = 0; n < ANGLE_STEPS; n++) begin : g_step
         qafr_cordic_cell #(.STEP(n)) u_cell (
            .clock     (clock),
            .enable    (adv),
            .prev_lane (chain[k][n]),
            .next_lane (chain[k][n+1])
         );
      end
   end

   qafr_delay #(.WIDTH($bits(qafr_pkg::angle_flags_type)), .DEPTH(ANGLE_STEPS)) u_flag_dly (
      .clock  (clock),
      .enable (adv),
      .d      (flags_ff),
      .q      (flags_end)
   );

   qafr_delay #(.WIDTH(96), .DEPTH(ST_OUT - 5)) u_earth_dly (
      .clock  (clock),
      .enable (adv),
      .d      ({e_ff[0], e_ff[1], e_ff[2]}),
      .q      (earth_end)
   );

   qafr_delay #(.WIDTH(96), .DEPTH(ST_OUT - 7)) u_free_dly (
      .clock  (clock),
      .enable (adv),
      .d      ({f_ff[0], f_ff[1], f_ff[2]}),
      .q      (free_end)
   );

   // Output register.
   assign roll_z  = qafr_pkg::clamp_angle(chain[0][ANGLE_STEPS].z, qafr_pkg::DEG180);
   assign yaw_z   = qafr_pkg::clamp_angle(chain[1][ANGLE_STEPS].z, qafr_pkg::DEG180);
   assign pitch_z = qafr_pkg::clamp_angle(chain[2][ANGLE_STEPS].z, qafr_pkg::DEG90);

   always_ff @(posedge clock) begin
      if (adv) begin
         earth_ff[0] <= earth_end[95:64];
         earth_ff[1] <= earth_end[63:32];
         earth_ff[2] <= earth_end[31:0];
         free_ff[0]  <= free_end[95:64];
         free_ff[1]  <= free_end[63:32];
         free_ff[2]  <= free_end[31:0];
         roll_ff <= flags_end.zero_roll ? 25'sd0 : roll_z[24:0];
         yaw_ff  <= flags_end.zero_yaw ? 25'sd0 : yaw_z[24:0];
         if (flags_end.sat_hi) begin
            pitch_ff <= -qafr_pkg::DEG90[23:0];
         end else if (flags_end.sat_lo) begin
            pitch_ff <= qafr_pkg::DEG90[23:0];
         end else if (flags_end.zero_pitch) begin
            pitch_ff <= 24'sd0;
         end else begin
            pitch_ff <= -pitch_z[23:0];
         end
      end
   end

   assign rsp_item.earth_accel_x = earth_ff[0];
   assign rsp_item.earth_accel_y = earth_ff[1];
   assign rsp_item.earth_accel_z = earth_ff[2];
   assign rsp_item.free_accel_x  = free_ff[0];
   assign rsp_item.free_accel_y  = free_ff[1];
   assign rsp_item.free_accel_z  = free_ff[2];
   assign rsp_item.roll_angle    = roll_ff;
   assign rsp_item.pitch_angle   = pitch_ff;
   assign rsp_item.yaw_angle     = yaw_ff;

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_item.valid && req_item.ready |=> valid_ff[0])
      else $error("Accepted item did not enter the pipeline.");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      valid_ff[DEPTH-1] && !rsp_item.ready |=> $stable(valid_ff))
      else $error("Pipeline moved while the output was stalled.");

   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_item.valid |-> (rsp_item.pitch_angle <= 24'sd5898240) &&
                         (rsp_item.pitch_angle >= -24'sd5898240))
      else $error("Pitch out of range.");

   a_roll_yaw_range: assert property (@(posedge clock) disable iff (reset)
      rsp_item.valid |-> (rsp_item.roll_angle <= 25'sd11796480) &&
                         (rsp_item.roll_angle >= -25'sd11796480) &&
                         (rsp_item.yaw_angle <= 25'sd11796480) &&
                         (rsp_item.yaw_angle >= -25'sd11796480))
      else $error("Roll or yaw out of range.");

   a_gravity_write: assert property (@(posedge clock) disable iff (reset)
      psel && penable && pwrite && (paddr[2] == qafr_pkg::CSR_IDX_GRAVITY)
      |=> gravity_ff == $past(pwdata[qafr_pkg::GRAVITY_W-1:0]))
      else $error("Gravity register write lost.");

endmodule

>>> design/qafr_delay.sv
// Enabled delay line used to align side data with the long chains.
// Depends on nothing.
module qafr_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             enable,
   input  logic [WIDTH-1:0] d,
   output logic [WIDTH-1:0] q
);

   logic [WIDTH-1:0] tap_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (enable) begin
         tap_ff[0] <= d;
         for (int n = 1; n < DEPTH; n++) begin
            tap_ff[n] <= tap_ff[n-1];
         end
      end
   end

   assign q = tap_ff[DEPTH-1];

endmodule

>>> design/qafr_sqrt_cell.sv
// One cell of the integer square root chain: settles one result bit.
// Depends on qafr_pkg for the lane type and widths.
module qafr_sqrt_cell #(
   parameter int STEP = 0
) (
   input  logic                    clock,
   input  logic                    enable,
   input  qafr_pkg::sqrt_lane_type prev_lane,
   output qafr_pkg::sqrt_lane_type next_lane
);

   localparam logic [qafr_pkg::ROOT_W-1:0] BIT_VAL =
      qafr_pkg::ROOT_W'(1) << (2 * (qafr_pkg::SQRT_STEPS - 1 - STEP));

   qafr_pkg::sqrt_lane_type lane_in;
   qafr_pkg::sqrt_lane_type lane_ff;
   logic [qafr_pkg::ROOT_W-1:0] trial;

   always_comb begin
      trial = prev_lane.res + BIT_VAL;
      if ({1'b0, prev_lane.v} >= trial) begin
         lane_in.v   = prev_lane.v - trial[qafr_pkg::REM_W-1:0];
         lane_in.res = (prev_lane.res >> 1) + BIT_VAL;
      end else begin
         lane_in.v   = prev_lane.v;
         lane_in.res = prev_lane.res >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         lane_ff <= lane_in;
      end
   end

   assign next_lane = lane_ff;

endmodule

>>> design/qafr_cordic_cell.sv
// One vectoring CORDIC iteration with its fixed shift and angle constant.
// Depends on qafr_pkg for the lane type and the arctangent table.
module qafr_cordic_cell #(
   parameter int STEP = 0
) (
   input  logic                      clock,
   input  logic                      enable,
   input  qafr_pkg::cordic_lane_type prev_lane,
   output qafr_pkg::cordic_lane_type next_lane
);

   localparam logic signed [qafr_pkg::ZW-1:0] ANGLE =
      qafr_pkg::ZW'(qafr_pkg::ATAN_TAB[STEP]);

   qafr_pkg::cordic_lane_type lane_in;
   qafr_pkg::cordic_lane_type lane_ff;
   logic signed [qafr_pkg::LANE_W-1:0] xs;
   logic signed [qafr_pkg::LANE_W-1:0] ys;

   always_comb begin
      xs = prev_lane.x >>> STEP;
      ys = prev_lane.y >>> STEP;
      if (prev_lane.y > 0) begin
         lane_in.x = prev_lane.x + ys;
         lane_in.y = prev_lane.y - xs;
         lane_in.z = prev_lane.z + ANGLE;
      end else begin
         lane_in.x = prev_lane.x - ys;
         lane_in.y = prev_lane.y + xs;
         lane_in.z = prev_lane.z - ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         lane_ff <= lane_in;
      end
   end

   assign next_lane = lane_ff;

endmodule

>>> tb/quaternion_attitude_and_frame_rotation_tb.sv
// Testbench for quaternion_attitude_and_frame_rotation: drives attitude items and
// gravity settings, predicts every result in a scoreboard class and checks each one.
// Depends on qafr_pkg, the qafr_req_if/qafr_rsp_if interfaces and the design files.
`timescale 1ns / 100ps

module quaternion_attitude_and_frame_rotation_tb;

   typedef struct {
      longint qw, qx, qy, qz, ax, ay, az;
   } attitude_item_type;

   typedef struct {
      logic signed [31:0] ex, ey, ez, fx, fy, fz;
      logic signed [24:0] roll;
      logic signed [23:0] pitch;
      logic signed [24:0] yaw;
   } motion_result_type;

   class motion_scoreboard;
      longint gravity;
      motion_result_type pending[$];
      int errors;

      function new();
         gravity = longint'(qafr_pkg::GRAVITY_RESET);
         errors = 0;
      endfunction

      function longint clip(longint v, longint lo, longint hi);
         return v < lo ? lo : (v > hi ? hi : v);
      endfunction

      function longint clip32(longint v);
         return clip(v, -64'sd2147483648, 64'sd2147483647);
      endfunction

      function longint rotate_row(longint r0, longint r1, longint r2,
                                  longint a0, longint a1, longint a2);
         return ((r0 * a0) >>> 30) + ((r1 * a1) >>> 30) + ((r2 * a2) >>> 30);
      endfunction

      function longint vector_angle(longint y, longint x);
         longint z, t, xs, ys;
         z = 0;
         if (y == 0 && x >= 0) begin
            return 0;
         end
         if (x < 0) begin
            if (y >= 0) begin
               t = x; x = y; y = -t; z = 5898240;
            end else begin
               t = x; x = -y; y = t; z = -5898240;
            end
         end
         for (int i = 0; i < qafr_pkg::ANGLE_STEPS_DEFAULT; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
               x = x + ys; y = y - xs; z += longint'(qafr_pkg::ATAN_TAB[i]);
            end else begin
               x = x - ys; y = y + xs; z -= longint'(qafr_pkg::ATAN_TAB[i]);
            end
         end
         return clip(z, -11796480, 11796480);
      endfunction

      function longint root_floor(longint unsigned v);
         longint unsigned res, bitv;
         res = 0;
         bitv = 64'd1 << 62;
         while (bitv > v) bitv >>= 2;
         while (bitv != 0) begin
            if (v >= res + bitv) begin
               v -= res + bitv;
               res = (res >> 1) + bitv;
            end else begin
               res >>= 1;
            end
            bitv >>= 2;
         end
         return longint'(res);
      endfunction

      function void note_attitude(attitude_item_type it);
         longint p00, p01, p02, p03, p11, p12, p13, p22, p23, p33;
         longint r00, r01, r02, r10, r11, r12, r20, r21, r22;
         longint ex, ey, ez, s, pitch;
         longint one;
         motion_result_type res;
         one = 64'sd1073741824;
         p00 = (it.qw * it.qw) >>> 30; p01 = (it.qw * it.qx) >>> 30;
         p02 = (it.qw * it.qy) >>> 30; p03 = (it.qw * it.qz) >>> 30;
         p11 = (it.qx * it.qx) >>> 30; p12 = (it.qx * it.qy) >>> 30;
         p13 = (it.qx * it.qz) >>> 30; p22 = (it.qy * it.qy) >>> 30;
         p23 = (it.qy * it.qz) >>> 30; p33 = (it.qz * it.qz) >>> 30;
         r00 = clip32(p00 + p11 - p22 - p33);
         r01 = clip32(2 * (p12 + p03));
         r02 = clip32(2 * (p13 - p02));
         r10 = clip32(2 * (p12 - p03));
         r11 = clip32(p00 - p11 + p22 - p33);
         r12 = clip32(2 * (p23 + p01));
         r20 = clip32(2 * (p13 + p02));
         r21 = clip32(2 * (p23 - p01));
         r22 = clip32(p00 - p11 - p22 + p33);
         ex = clip32(rotate_row(r00, r10, r20, it.ax, it.ay, it.az));
         ey = clip32(rotate_row(r01, r11, r21, it.ax, it.ay, it.az));
         ez = clip32(rotate_row(r02, r12, r22, it.ax, it.ay, it.az) - gravity);
         res.ex = 32'(ex); res.ey = 32'(ey); res.ez = 32'(ez);
         res.fx = 32'(clip32(rotate_row(r00, r01, r02, ex, ey, ez)));
         res.fy = 32'(clip32(rotate_row(r10, r11, r12, ex, ey, ez)));
         res.fz = 32'(clip32(rotate_row(r20, r21, r22, ex, ey, ez)));
         res.roll = 25'(vector_angle(2 * (p01 + p23), one - 2 * (p11 + p22)));
         res.yaw = 25'(vector_angle(2 * (p12 + p03), one - 2 * (p22 + p33)));
         s = 2 * (p02 - p13);
         if (s >= one) begin
            pitch = -5898240;
         end else if (s <= -one) begin
            pitch = 5898240;
         end else begin
            pitch = -clip(vector_angle(s, root_floor(one * one - s * s)), -5898240, 5898240);
         end
         res.pitch = 24'(pitch);
         pending.push_back(res);
      endfunction

      function void compare(string name, longint exp_v, longint act_v);
         if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
         end
      endfunction

      function void check_motion(motion_result_type act);
         motion_result_type e;
         if (pending.size() == 0) begin
            $error("result arrived with no item outstanding");
            errors++;
            return;
         end
         e = pending.pop_front();
         compare("earth_accel_x", e.ex, act.ex);
         compare("earth_accel_y", e.ey, act.ey);
         compare("earth_accel_z", e.ez, act.ez);
         compare("free_accel_x", e.fx, act.fx);
         compare("free_accel_y", e.fy, act.fy);
         compare("free_accel_z", e.fz, act.fz);
         compare("roll_angle", e.roll, act.roll);
         compare("pitch_angle", e.pitch, act.pitch);
         compare("yaw_angle", e.yaw, act.yaw);
      endfunction
   endclass

   localparam int LATENCY = qafr_pkg::ANGLE_STEPS_DEFAULT + 37;
   localparam longint CYCLE_LIMIT = 2000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [qafr_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   qafr_req_if req_item();
   qafr_rsp_if rsp_item();

   quaternion_attitude_and_frame_rotation dut (
      .clock(clock), .reset(reset), .req_item(req_item), .rsp_item(rsp_item),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   motion_scoreboard board = new();
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_left = 0;
   longint cycles = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      req_item.valid = 1'b0;
      req_item.quat_w = '0; req_item.quat_x = '0; req_item.quat_y = '0;
      req_item.quat_z = '0; req_item.accel_body_x = '0;
      req_item.accel_body_y = '0; req_item.accel_body_z = '0;
      rsp_item.ready = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("quaternion_attitude_and_frame_rotation_tb: FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_item.ready <= 1'b0;
      end else begin
         rsp_item.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      attitude_item_type it;
      motion_result_type act;
      if (!reset && req_item.valid && req_item.ready) begin
         it.qw = longint'(req_item.quat_w); it.qx = longint'(req_item.quat_x);
         it.qy = longint'(req_item.quat_y); it.qz = longint'(req_item.quat_z);
         it.ax = longint'(req_item.accel_body_x);
         it.ay = longint'(req_item.accel_body_y);
         it.az = longint'(req_item.accel_body_z);
         board.note_attitude(it);
      end
      if (!reset && rsp_item.valid && rsp_item.ready) begin
         act.ex = rsp_item.earth_accel_x; act.ey = rsp_item.earth_accel_y;
         act.ez = rsp_item.earth_accel_z; act.fx = rsp_item.free_accel_x;
         act.fy = rsp_item.free_accel_y; act.fz = rsp_item.free_accel_z;
         act.roll = rsp_item.roll_angle; act.pitch = rsp_item.pitch_angle;
         act.yaw = rsp_item.yaw_angle;
         board.check_motion(act);
      end
   end

   task automatic write_gravity(int index, logic [31:0] value);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= qafr_pkg::CSR_ADDR_W'(4 * index); pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      if (index == qafr_pkg::CSR_IDX_GRAVITY) begin
         board.gravity = longint'(value & 32'h3FFFFF);
      end
   endtask

   task automatic send_attitude(int qw, int qx, int qy, int qz, int ax, int ay, int az);
      int gap;
      if ($urandom_range(99) < send_idle_pct) begin
         gap = $urandom_range(1, 4);
         req_item.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_item.valid <= 1'b1;
      req_item.quat_w <= qw; req_item.quat_x <= qx;
      req_item.quat_y <= qy; req_item.quat_z <= qz;
      req_item.accel_body_x <= ax; req_item.accel_body_y <= ay;
      req_item.accel_body_z <= az;
      do @(posedge clock); while (!req_item.ready);
   endtask

   task automatic drain_pipeline();
      req_item.valid <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   function automatic int accel_value();
      if ($urandom_range(99) < 70) begin
         return int'($urandom_range(4194304)) - 2097152;
      end
      return int'($urandom);
   endfunction

   task automatic send_random_attitude();
      real cw, cx, cy, cz, mag, scale;
      if ($urandom_range(99) < 75) begin
         cw = real'($urandom_range(2000)) - 1000.0;
         cx = real'($urandom_range(2000)) - 1000.0;
         cy = real'($urandom_range(2000)) - 1000.0;
         cz = real'($urandom_range(2000)) - 1000.0;
         mag = $sqrt(cw * cw + cx * cx + cy * cy + cz * cz) + 1.0;
         scale = (($urandom_range(9) == 0) ? 1.9 : 1.0) * 1073741824.0 / mag;
         send_attitude($rtoi(cw * scale), $rtoi(cx * scale), $rtoi(cy * scale),
                       $rtoi(cz * scale), accel_value(), accel_value(), accel_value());
      end else begin
         send_attitude($urandom, $urandom, $urandom, $urandom,
                       accel_value(), accel_value(), accel_value());
      end
   endtask

   initial begin
      int one;
      int half;
      int idle_set[4];
      int stall_set[4];
      logic [31:0] grav_set[4];
      one = 1073741824;
      half = 536870912;
      idle_set = '{0, 65, 0, 25};
      stall_set = '{0, 0, 65, 25};
      grav_set = '{32'd642690, 32'd0, 32'd2097152, 32'd0};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_attitude(one, 0, 0, 0, 0, 0, 642690);
      send_attitude(one, 0, 0, 0, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
      send_attitude(0, 0, 0, 0, 65536, -65536, 65536);
      send_attitude(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                    32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
      send_attitude(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                    32'sh80000000, 32'sh80000000, 32'sh80000000);
      send_attitude(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                    -1, 0, 1);
      send_attitude(one, 0, one, 0, 100000, 200000, -300000);
      send_attitude(one, 0, -one, 0, -100000, 50000, 300000);
      send_attitude(half, 0, half, 0, 65536, 65536, 65536);
      send_attitude(0, half, half, 0, 1000, -1000, 642690);
      send_attitude(0, one, 0, 0, 0, 0, -642690);
      send_attitude(0, 0, 0, one, 123456, -654321, 0);
      send_attitude(-one, 0, 0, 0, 1, 1, 1);
      send_attitude(759250125, 0, 0, 759250125, 500000, 0, 0);
      send_attitude(759250125, 759250125, 0, 0, 0, 500000, 0);
      send_attitude(-1, -1, -1, -1, -1, -1, -1);
      drain_pipeline();
      write_gravity(1, 32'd12345);

      for (int ph = 0; ph < 4; ph++) begin
         if (ph > 0) begin
            drain_pipeline();
            write_gravity(qafr_pkg::CSR_IDX_GRAVITY,
                          ph == 3 ? 32'($urandom_range(2097152)) : grav_set[ph]);
         end
         send_idle_pct = idle_set[ph];
         recv_stall_pct = stall_set[ph];
         if (ph == 0) hold_left = 300;
         for (int n = 0; n < 450; n++) send_random_attitude();
      end

      drain_pipeline();
      write_gravity(qafr_pkg::CSR_IDX_GRAVITY, 32'd642690);
      repeat (10) send_random_attitude();
      drain_pipeline();
      if (board.errors == 0) begin
         $display("quaternion_attitude_and_frame_rotation_tb: PASS");
      end else begin
         $display("quaternion_attitude_and_frame_rotation_tb: FAIL");
      end
      $finish;
   end
endmodule

>>> sim.f
design/qafr_pkg.sv
design/qafr_if.sv
design/qafr_delay.sv
design/qafr_sqrt_cell.sv
design/qafr_cordic_cell.sv
design/quaternion_attitude_and_frame_rotation.sv
tb/quaternion_attitude_and_frame_rotation_tb.sv
